// ===== hw/rtl/pfa_pkg.sv =====
// Shared codes and controller/datapath handshake types for the page frame allocator.
package pfa_pkg;

    // Operation codes carried by an input word.
    localparam logic [1:0] OP_ALLOC      = 2'd0;
    localparam logic [1:0] OP_FREE_FRAME = 2'd1;
    localparam logic [1:0] OP_SET_USAGE  = 2'd2;
    localparam logic [1:0] OP_FREE_SWAP  = 2'd3;

    // Status codes carried by a result word.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_VICTIM = 2'd1;
    localparam logic [1:0] STAT_SWAP_FULL = 2'd2;

    // Best NRU rank seen so far when no unpinned frame has been found.
    localparam logic [2:0] RANK_NONE = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_load;    // latch the input word and start a new step
        logic       clr_step;   // clear one entry of each memory
        logic       f_read;     // read frame memory at the scan pointer
        logic       f_read_fi;  // read frame memory at the requested frame
        logic       f_take;     // claim the free frame just read
        logic       v_step;     // fold the frame just read into the victim search
        logic       s_read;     // read swap memory at the slot pointer
        logic       evict;      // commit the victim and the free slot just read
        logic       rmw_wr;     // write back a free or a usage update
        logic       swap_rel;   // release the requested swap slot
        logic       stat_en;    // record a status code
        logic [1:0] stat_val;
        logic       out_load;   // move the result into the output register
    } pfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       fi_ok;
        logic       have_free;
        logic       f_hit;
        logic       v_last;
        logic       v_none;
        logic       s_hit;
        logic       s_last;
    } pfa_sts_t;

endpackage

// ===== hw/rtl/pfa_dpath.sv =====
// Datapath of the page frame allocator: frame and swap memories, pointers and result registers.
module pfa_dpath #(
    parameter int FRAMES     = 64,
    parameter int SWAP_SLOTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pfa_pkg::pfa_cmd_t cmd,
    output pfa_pkg::pfa_sts_t sts,
    input  logic [1:0]       operation,
    input  logic [5:0]       frame_index,
    input  logic             pin,
    input  logic             accessed,
    input  logic             dirty,
    input  logic [5:0]       swap_slot,
    output logic [5:0]       frame,
    output logic             evicted,
    output logic [5:0]       swap_slot_out,
    output logic [1:0]       status,
    output logic [6:0]       free_frames
);

    localparam int FW      = $clog2(FRAMES);
    localparam int SW      = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
    localparam int CLR_LEN = (FRAMES > SWAP_SLOTS) ? FRAMES : SWAP_SLOTS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int NW      = $clog2(FRAMES + 1);

    typedef struct packed {
        logic used;
        logic pinned;
        logic accessed;
        logic dirty;
    } frame_ent_t;

    // Memories.
    frame_ent_t fmem [FRAMES];
    logic       smem [SWAP_SLOTS];

    // Control registers.
    logic [FW-1:0] next_frame_reg, next_frame_next;
    logic [NW-1:0] free_count_reg, free_count_next;
    logic [CW-1:0] clr_cnt_reg;
    logic          f_rvld_reg;
    logic          s_rvld_reg;

    // Payload registers.
    logic [1:0]    op_reg;
    logic [5:0]    fi_reg;
    logic          pin_reg;
    logic          acc_reg;
    logic          dir_reg;
    logic [5:0]    ss_reg;
    logic [FW-1:0] iptr_reg, iptr_next;
    logic [SW-1:0] sptr_reg, sptr_next;
    frame_ent_t    f_rdata_reg;
    logic [FW-1:0] f_raddr_reg;
    logic          s_rdata_reg;
    logic [SW-1:0] s_raddr_reg;
    logic [2:0]    best_reg;
    logic [FW-1:0] vic_reg;
    logic [FW-1:0] res_frame_reg;
    logic          res_evicted_reg;
    logic [SW-1:0] res_slot_reg;
    logic [1:0]    res_status_reg;
    logic [5:0]    frame_reg;
    logic          evicted_reg;
    logic [5:0]    swap_slot_out_reg;
    logic [1:0]    status_reg;
    logic [6:0]    free_frames_reg;

    logic          fi_ok;
    logic          ss_ok;
    logic [FW-1:0] fi_addr;
    logic [1:0]    rank;
    logic          f_re;
    logic [FW-1:0] f_raddr;
    logic          f_we;
    logic [FW-1:0] f_waddr;
    frame_ent_t    f_wdata;
    logic          s_we;
    logic [SW-1:0] s_waddr;
    logic          s_wdata;
    frame_ent_t    taken;

    // Range checks and derived values.
    assign fi_ok   = 32'(fi_reg) < 32'(FRAMES);
    assign ss_ok   = 32'(ss_reg) < 32'(SWAP_SLOTS);
    assign fi_addr = FW'(fi_reg);
    assign rank    = {f_rdata_reg.dirty, f_rdata_reg.accessed};
    assign taken   = '{used: 1'b1, pinned: pin_reg, accessed: 1'b0, dirty: 1'b0};

    // Scan pointers advance with wrap.
    assign iptr_next = (iptr_reg == FW'(FRAMES - 1)) ? '0 : iptr_reg + FW'(1);
    assign sptr_next = (sptr_reg == SW'(SWAP_SLOTS - 1)) ? '0 : sptr_reg + SW'(1);

    // Status back to the controller.
    always_comb
    begin
        sts.op        = op_reg;
        sts.clr_last  = (clr_cnt_reg == CW'(CLR_LEN - 1));
        sts.fi_ok     = fi_ok;
        sts.have_free = (free_count_reg != '0);
        sts.f_hit     = f_rvld_reg && !f_rdata_reg.used;
        sts.v_last    = f_rvld_reg && ((f_raddr_reg == FW'(FRAMES - 1)) ||
                        (!f_rdata_reg.pinned && rank == 2'd0));
        sts.v_none    = (best_reg == pfa_pkg::RANK_NONE);
        sts.s_hit     = s_rvld_reg && !s_rdata_reg;
        sts.s_last    = s_rvld_reg && (s_raddr_reg == SW'(SWAP_SLOTS - 1));
    end

    // Frame memory read port.
    assign f_re    = cmd.f_read || cmd.f_read_fi;
    assign f_raddr = cmd.f_read_fi ? fi_addr : iptr_reg;

    // Frame memory write port; the commands that write never coincide.
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = f_raddr_reg;
        f_wdata = f_rdata_reg;
        priority if (cmd.clr_step)
        begin
            f_we    = 32'(clr_cnt_reg) < 32'(FRAMES);
            f_waddr = FW'(clr_cnt_reg);
            f_wdata = '0;
        end
        else if (cmd.f_take)
        begin
            f_we    = 1'b1;
            f_wdata = taken;
        end
        else if (cmd.evict)
        begin
            f_we    = 1'b1;
            f_waddr = vic_reg;
            f_wdata = taken;
        end
        else if (cmd.rmw_wr)
        begin
            if (op_reg == pfa_pkg::OP_FREE_FRAME)
            begin
                f_we         = f_rdata_reg.used;
                f_wdata.used = 1'b0;
            end
            else
            begin
                f_we             = 1'b1;
                f_wdata.accessed = acc_reg;
                f_wdata.dirty    = dir_reg;
            end
        end
        else
        begin
            f_we = 1'b0;
        end
    end

    // Swap memory write port.
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = s_raddr_reg;
        s_wdata = 1'b0;
        priority if (cmd.clr_step)
        begin
            s_we    = 32'(clr_cnt_reg) < 32'(SWAP_SLOTS);
            s_waddr = SW'(clr_cnt_reg);
        end
        else if (cmd.evict)
        begin
            s_we    = 1'b1;
            s_wdata = 1'b1;
        end
        else if (cmd.swap_rel)
        begin
            s_we    = ss_ok;
            s_waddr = SW'(ss_reg);
        end
        else
        begin
            s_we = 1'b0;
        end
    end

    // Memory arrays with registered read data.
    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fmem[f_waddr] <= f_wdata;
        end
        if (f_re)
        begin
            f_rdata_reg <= fmem[f_raddr];
            f_raddr_reg <= f_raddr;
        end
        if (s_we)
        begin
            smem[s_waddr] <= s_wdata;
        end
        if (cmd.s_read)
        begin
            s_rdata_reg <= smem[sptr_reg];
            s_raddr_reg <= sptr_reg;
        end
    end

    // Next values of the pointer and the free count.
    always_comb
    begin
        next_frame_next = next_frame_reg;
        free_count_next = free_count_reg;
        if (cmd.f_take)
        begin
            next_frame_next = (f_raddr_reg == FW'(FRAMES - 1)) ? '0 : f_raddr_reg + FW'(1);
            free_count_next = free_count_reg - NW'(1);
        end
        else if (cmd.rmw_wr && op_reg == pfa_pkg::OP_FREE_FRAME && f_rdata_reg.used)
        begin
            free_count_next = free_count_reg + NW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_frame_reg <= '0;
            free_count_reg <= NW'(FRAMES);
            clr_cnt_reg    <= '0;
            f_rvld_reg     <= 1'b0;
            s_rvld_reg     <= 1'b0;
        end
        else
        begin
            next_frame_reg <= next_frame_next;
            free_count_reg <= free_count_next;
            f_rvld_reg     <= f_re;
            s_rvld_reg     <= cmd.s_read;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
        end
    end

    // Input word, scan state and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg          <= operation;
            fi_reg          <= frame_index;
            pin_reg         <= pin;
            acc_reg         <= accessed;
            dir_reg         <= dirty;
            ss_reg          <= swap_slot;
            iptr_reg        <= (free_count_reg == '0) ? '0 : next_frame_reg;
            sptr_reg        <= '0;
            best_reg        <= pfa_pkg::RANK_NONE;
            vic_reg         <= '0;
            res_frame_reg   <= '0;
            res_evicted_reg <= 1'b0;
            res_slot_reg    <= '0;
            res_status_reg  <= pfa_pkg::STAT_OK;
        end
        else
        begin
            if (cmd.f_read)
            begin
                iptr_reg <= iptr_next;
            end
            if (cmd.s_read)
            begin
                sptr_reg <= sptr_next;
            end
            if (cmd.v_step && f_rvld_reg && !f_rdata_reg.pinned && ({1'b0, rank} < best_reg))
            begin
                best_reg <= {1'b0, rank};
                vic_reg  <= f_raddr_reg;
            end
            if (cmd.f_take)
            begin
                res_frame_reg <= f_raddr_reg;
            end
            if (cmd.evict)
            begin
                res_frame_reg   <= vic_reg;
                res_evicted_reg <= 1'b1;
                res_slot_reg    <= s_raddr_reg;
            end
            if (cmd.stat_en)
            begin
                res_status_reg <= cmd.stat_val;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            frame_reg         <= 6'(res_frame_reg);
            evicted_reg       <= res_evicted_reg;
            swap_slot_out_reg <= 6'(res_slot_reg);
            status_reg        <= res_status_reg;
            free_frames_reg   <= 7'(free_count_reg);
        end
    end

    assign frame         = frame_reg;
    assign evicted       = evicted_reg;
    assign swap_slot_out = swap_slot_out_reg;
    assign status        = status_reg;
    assign free_frames   = free_frames_reg;

endmodule

// ===== hw/rtl/pfa_ctrl.sv =====
// Controller of the page frame allocator: sequences clearing, scans, updates and handshakes.
module pfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  pfa_pkg::pfa_sts_t sts,
    output pfa_pkg::pfa_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_FSCAN  = 4'd3;
    localparam logic [3:0] S_VSCAN  = 4'd4;
    localparam logic [3:0] S_VDEC   = 4'd5;
    localparam logic [3:0] S_SSCAN  = 4'd6;
    localparam logic [3:0] S_RMW    = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The output register can take a word when empty or being emptied.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    pfa_pkg::OP_ALLOC:
                    begin
                        cmd.f_read = 1'b1;
                        state_next = sts.have_free ? S_FSCAN : S_VSCAN;
                    end
                    pfa_pkg::OP_FREE_FRAME, pfa_pkg::OP_SET_USAGE:
                    begin
                        cmd.f_read_fi = sts.fi_ok;
                        state_next    = sts.fi_ok ? S_RMW : S_RESP;
                    end
                    pfa_pkg::OP_FREE_SWAP:
                    begin
                        cmd.swap_rel = 1'b1;
                        state_next   = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_FSCAN:
            begin
                if (sts.f_hit)
                begin
                    cmd.f_take = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.f_read = 1'b1;
                end
            end
            S_VSCAN:
            begin
                cmd.v_step = 1'b1;
                if (sts.v_last)
                begin
                    state_next = S_VDEC;
                end
                else
                begin
                    cmd.f_read = 1'b1;
                end
            end
            S_VDEC:
            begin
                if (sts.v_none)
                begin
                    cmd.stat_en  = 1'b1;
                    cmd.stat_val = pfa_pkg::STAT_NO_VICTIM;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.s_read = 1'b1;
                    state_next = S_SSCAN;
                end
            end
            S_SSCAN:
            begin
                if (sts.s_hit)
                begin
                    cmd.evict  = 1'b1;
                    state_next = S_RESP;
                end
                else if (sts.s_last)
                begin
                    cmd.stat_en  = 1'b1;
                    cmd.stat_val = pfa_pkg::STAT_SWAP_FULL;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.s_read = 1'b1;
                end
            end
            S_RMW:
            begin
                cmd.rmw_wr = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed transfers.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/page_frame_allocator_nru_unit.sv =====
// Allocate with a free frame: the result follows a scan from the next-frame pointer.
// Allocate with eviction: a victim scan over the frames, then a scan for a free swap slot.
// Free frame and set usage read the entry, then write it back; one word is held at a time.
// A stalled result delays its load; the next word is accepted the cycle after the load.
// Each scan reads one memory entry per cycle through a registered read port.
// After reset a clearing pass over both memories runs before any word is taken.
module page_frame_allocator_nru_unit #(
    parameter int FRAMES     = 64,
    parameter int SWAP_SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [5:0] frame_index,
    input  logic       pin,
    input  logic       accessed,
    input  logic       dirty,
    input  logic [5:0] swap_slot,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] frame,
    output logic       evicted,
    output logic [5:0] swap_slot_out,
    output logic [1:0] status,
    output logic [6:0] free_frames
);

    pfa_pkg::pfa_cmd_t cmd;
    pfa_pkg::pfa_sts_t sts;

    // Sequencing and handshakes.
    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Memories, pointers and result fields.
    pfa_dpath #(
        .FRAMES     (FRAMES),
        .SWAP_SLOTS (SWAP_SLOTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .frame_index   (frame_index),
        .pin           (pin),
        .accessed      (accessed),
        .dirty         (dirty),
        .swap_slot     (swap_slot),
        .frame         (frame),
        .evicted       (evicted),
        .swap_slot_out (swap_slot_out),
        .status        (status),
        .free_frames   (free_frames)
    );

endmodule
